### src/shortest_remaining_time_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shortest-remaining-time scheduler
// Each macro checks an implication, clocked on clk and held off by reset.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_TOP_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Word formats, operation codes, chain token flags and controller states
// shared by the scheduler cells and the top level.
// ----------------------------------------------------------------------------
package srtf_pkg;

	// Operation codes carried in the input word.
	localparam logic OP_ADMIT = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Input word: admit a burst into a slot, or advance time by one tick.
	typedef struct packed {
		logic        operation;
		logic [3:0]  slot;
		logic [15:0] burst;
	} in_word_t;

	// Result word, one per tick.
	typedef struct packed {
		logic        ran_valid;
		logic [3:0]  ran_slot;
		logic [15:0] remaining_after;
		logic        finished;
		logic        all_done;
	} out_word_t;

	// Flags of the search token that travels along the cell chain.
	typedef struct packed {
		logic valid;
		logic found;
		logic multi;
	} tok_flags_t;

	// Write command broadcast to every cell.
	typedef struct packed {
		logic admit;
		logic dec;
	} cell_cmd_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

### src/shortest_remaining_time_scheduler_top.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_top
// An admit writes its slot and gives no result; a tick gives its result once
// the search token has walked the chain of slot cells, one cell per cycle,
// and the result word is registered. No word is taken while a scan runs, so
// a new tick waits until the last scan is done and the result register is free.
// Reset clears every slot's remaining time at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "shortest_remaining_time_scheduler_top_macros.svh"

module shortest_remaining_time_scheduler_top
	import srtf_pkg::*;
#(
	parameter int NUM_SLOTS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	state_t    state_q;
	state_t    state_d;
	logic      out_valid_q;
	out_word_t out_word_q;

	logic      in_acc;
	logic      tick_acc;
	logic      admit_acc;
	logic      scan_done;
	cell_cmd_t cmd;
	logic [IDX_W-1:0]     cmd_idx;
	logic [TIME_BITS-1:0] cmd_value;
	logic [TIME_BITS-1:0] best_dec;
	out_word_t result;

	tok_flags_t           tok_flags [NUM_SLOTS+1];
	logic [IDX_W-1:0]     tok_idx   [NUM_SLOTS+1];
	logic [TIME_BITS-1:0] tok_val   [NUM_SLOTS+1];
	logic [NUM_SLOTS-1:0] tok_valids;

	// Handshake decode.
	assign in_acc    = in_valid && in_ready;
	assign tick_acc  = in_acc && (in_word.operation == OP_TICK);
	assign admit_acc = in_acc && (in_word.operation == OP_ADMIT);
	assign scan_done = tok_flags[NUM_SLOTS].valid;

	// Controller: a tick waits until the result register is free or freeing.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = (in_word.operation == OP_ADMIT) || !out_valid_q || out_ready;
				if (tick_acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The token enters the first cell as a tick word is accepted.
	assign tok_flags[0] = '{valid: tick_acc, found: 1'b0, multi: 1'b0};
	assign tok_idx[0]   = '0;
	assign tok_val[0]   = '0;

	// Write command: an admit to a slot in range, or the winner's decrement.
	always_comb begin
		cmd.admit = admit_acc && (32'(in_word.slot) < NUM_SLOTS);
		cmd.dec   = scan_done && tok_flags[NUM_SLOTS].found;
		cmd_idx   = scan_done ? tok_idx[NUM_SLOTS] : IDX_W'(in_word.slot);
		cmd_value = TIME_BITS'(in_word.burst);
	end

	// Chain of slot cells.
	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		srtf_cell #(
			.TIME_BITS (TIME_BITS),
			.IDX_W     (IDX_W),
			.CELL_IDX  (g)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.cmd_idx       (cmd_idx),
			.cmd_value     (cmd_value),
			.tok_in_flags  (tok_flags[g]),
			.tok_in_idx    (tok_idx[g]),
			.tok_in_val    (tok_val[g]),
			.tok_out_flags (tok_flags[g+1]),
			.tok_out_idx   (tok_idx[g+1]),
			.tok_out_val   (tok_val[g+1])
		);
		assign tok_valids[g] = tok_flags[g+1].valid;
	end

	// Result word from the token leaving the last cell. Work is left after
	// the tick if a second slot was busy or the winner did not finish.
	always_comb begin
		best_dec = tok_val[NUM_SLOTS] - TIME_BITS'(1);
		result   = '0;
		if (tok_flags[NUM_SLOTS].found) begin
			result.ran_valid       = 1'b1;
			result.ran_slot        = 4'(tok_idx[NUM_SLOTS]);
			result.remaining_after = 16'(best_dec);
			result.finished        = (best_dec == '0);
		end
		result.all_done = !(tok_flags[NUM_SLOTS].multi ||
			(tok_flags[NUM_SLOTS].found && (best_dec != '0)));
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// At most one search token is in flight along the chain.
	`SRTF_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_valids), "more than one token in the chain")
	// A token leaves the chain only while a scan is running.
	`SRTF_ASSERT_NOW(a_done_in_scan, scan_done, state_q == ST_SCAN, "token left chain outside a scan")
	// An accepted tick always starts a scan.
	`SRTF_ASSERT_NEXT(a_tick_scans, tick_acc, state_q == ST_SCAN, "tick accepted without a scan")
	// A finished scan always leaves a result waiting.
	`SRTF_ASSERT_NEXT(a_result_held, scan_done, out_valid_q, "scan finished without a result")

endmodule

### src/srtf_cell.sv
// ----------------------------------------------------------------------------
// srtf_cell
// One process slot: holds the slot's remaining time and forwards the search
// token to the next cell, replacing the best candidate when this slot wins.
// ----------------------------------------------------------------------------
module srtf_cell
	import srtf_pkg::*;
#(
	parameter int TIME_BITS = 16,
	parameter int IDX_W     = 4,
	parameter int CELL_IDX  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_cmd_t            cmd,
	input  logic [IDX_W-1:0]     cmd_idx,
	input  logic [TIME_BITS-1:0] cmd_value,
	input  tok_flags_t           tok_in_flags,
	input  logic [IDX_W-1:0]     tok_in_idx,
	input  logic [TIME_BITS-1:0] tok_in_val,
	output tok_flags_t           tok_out_flags,
	output logic [IDX_W-1:0]     tok_out_idx,
	output logic [TIME_BITS-1:0] tok_out_val
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [TIME_BITS-1:0] rem_q;
	tok_flags_t           tok_flags_q;
	logic [IDX_W-1:0]     tok_idx_q;
	logic [TIME_BITS-1:0] tok_val_q;

	logic       busy;
	logic       take;
	logic       hit;
	tok_flags_t tok_flags_d;

	// This slot wins if it has work and beats the best so far strictly,
	// so that a tie stays with the lower slot further up the chain.
	always_comb begin
		busy = (rem_q != '0);
		take = busy && (!tok_in_flags.found || (rem_q < tok_in_val));
		hit  = (cmd_idx == MY_IDX);
		tok_flags_d.valid = tok_in_flags.valid;
		tok_flags_d.found = tok_in_flags.found || busy;
		tok_flags_d.multi = tok_in_flags.multi || (tok_in_flags.found && busy);
	end

	// Remaining time: loaded by an admit, stepped down when this slot runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cmd.admit && hit) begin
			rem_q <= cmd_value;
		end else if (cmd.dec && hit) begin
			rem_q <= rem_q - TIME_BITS'(1);
		end
	end

	// Token flags move one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_flags_q <= '0;
		end else begin
			tok_flags_q <= tok_flags_d;
		end
	end

	// Best candidate so far.
	always_ff @(posedge clk) begin
		tok_idx_q <= take ? MY_IDX : tok_in_idx;
		tok_val_q <= take ? rem_q : tok_in_val;
	end

	assign tok_out_flags = tok_flags_q;
	assign tok_out_idx   = tok_idx_q;
	assign tok_out_val   = tok_val_q;

endmodule
